[rtl/rdw_pkg.sv]
`default_nettype none
package rdw_pkg;

  // Coefficient registers are signed Q3.12
  localparam int COEFF_WIDTH = 16;
  localparam int COEFF_FRAC  = 12;

  localparam int STATUS_WIDTH = 2;
  localparam int CFG_INDEX_WIDTH = 1;

  typedef logic [STATUS_WIDTH-1:0]    status_t;
  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

  localparam status_t STATUS_OK  = 2'd0;
  localparam status_t STATUS_SAT = 2'd1;
  localparam status_t STATUS_ERR = 2'd2;

  localparam cfg_index_t CFG_K1 = 1'b0;
  localparam cfg_index_t CFG_K2 = 1'b1;

  // Per-word flags that ride the divider stages
  typedef struct packed {
    logic neg_u;
    logic neg_v;
    logic ovf_u;
    logic ovf_v;
    logic err;
  } rdw_flags_t;

endpackage
`default_nettype wire

[rtl/rdw_in_if.sv]
`default_nettype none
interface rdw_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] coord_u;
  logic [COORD_WIDTH-1:0] coord_v;

  modport source (output valid, output coord_u, output coord_v, input ready);
  modport sink   (input valid, input coord_u, input coord_v, output ready);
endinterface
`default_nettype wire

[rtl/rdw_out_if.sv]
`default_nettype none
interface rdw_out_if import rdw_pkg::*; #(
  parameter int COORD_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] warped_s;
  logic [COORD_WIDTH-1:0] warped_t;
  status_t                status_code;

  modport source (output valid, output warped_s, output warped_t, output status_code,
                  input ready);
  modport sink   (input valid, input warped_s, input warped_t, input status_code,
                  output ready);
endinterface
`default_nettype wire

[rtl/radial_distortion_warp.sv]
`default_nettype none
// Channel   Dir  Fields                               Handshake
// in_chan   in   coord_u, coord_v (signed Q1.F)       valid/ready
// out_chan  out  warped_s, warped_t (signed Q1.F),    valid/ready
//                status_code
// cfg_*     in   cfg_index, cfg_data (k1, k2 Q3.12)   cfg_wr_en, no wait
//
// One word enters per cycle while out_chan is not stalled. The pipeline holds six
// stages of magnitudes, squares, products and the denominator, one setup stage, one
// restoring divider step per quotient bit (COORD_WIDTH + 1), one output stage.
// Synchronous active-low reset clears the valid bits and the coefficients.
// A stall on out_chan freezes the whole pipeline; in_chan.ready drops with it.
module radial_distortion_warp import rdw_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  rdw_in_if.sink                      in_chan,
  rdw_out_if.source                   out_chan,
  input  wire logic                   cfg_wr_en,
  input  wire cfg_index_t             cfg_index,
  input  wire logic [COEFF_WIDTH-1:0] cfg_data
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = W - 2;
  localparam int R2W = W + 2;                     // r2 <= 2^(W+1)
  localparam int R4W = W + 5;                     // r4 <= 2^(W+4)
  localparam int K1W = COEFF_WIDTH + R2W + 1;
  localparam int DW  = COEFF_WIDTH + R4W + 1;     // denominator, signed
  localparam int QW  = W + 1;                     // quotient with one rounding bit
  localparam int PRE = F + COEFF_FRAC + 1 - QW;   // numerator bits before the steps

  localparam logic signed [DW-1:0] D_ONE =
    {{(DW-F-COEFF_FRAC-1){1'b0}}, 1'b1, {(F+COEFF_FRAC){1'b0}}};
  localparam logic [QW-1:0] LIM_NEG = {2'b01, {(W-1){1'b0}}};
  localparam logic [QW-1:0] LIM_POS = LIM_NEG - 1'b1;

  logic adv;

  // Coefficient registers
  logic signed [COEFF_WIDTH-1:0] k1_r, k2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r <= '0;
      k2_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_K1:  k1_r <= cfg_data;
        CFG_K2:  k2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: magnitudes and signs
  logic         v1_r;
  logic [W-1:0] au1_r, av1_r;
  logic         nu1_r, nv1_r;
  logic [W-1:0] au_nxt, av_nxt;

  assign au_nxt = in_chan.coord_u[W-1] ? (~in_chan.coord_u + 1'b1) : in_chan.coord_u;
  assign av_nxt = in_chan.coord_v[W-1] ? (~in_chan.coord_v + 1'b1) : in_chan.coord_v;

  // Stage 2: squares
  logic           v2_r;
  logic [2*W-1:0] pu2_r, pv2_r;
  logic [W-1:0]   au2_r, av2_r;
  logic           nu2_r, nv2_r;
  logic [2*W-1:0] pu_nxt, pv_nxt;

  assign pu_nxt = au1_r * au1_r;
  assign pv_nxt = av1_r * av1_r;

  // Stage 3: r2
  logic           v3_r;
  logic [R2W-1:0] r2_3_r;
  logic [W-1:0]   au3_r, av3_r;
  logic           nu3_r, nv3_r;
  logic [2*W-1:0] sum_nxt;

  assign sum_nxt = pu2_r + pv2_r;

  // Stage 4: r2 squared and k1*r2
  logic                  v4_r;
  logic [2*R2W-1:0]      r2sq4_r;
  logic signed [K1W-1:0] k1r2_4_r;
  logic [W-1:0]          au4_r, av4_r;
  logic                  nu4_r, nv4_r;
  logic [2*R2W-1:0]      r2sq_nxt;
  logic signed [K1W-1:0] k1r2_nxt;

  assign r2sq_nxt = r2_3_r * r2_3_r;
  assign k1r2_nxt = k1_r * $signed({1'b0, r2_3_r});

  // Stage 5: k2*r4
  logic                  v5_r;
  logic signed [DW-1:0]  k2r4_5_r;
  logic signed [K1W-1:0] k1r2_5_r;
  logic [W-1:0]          au5_r, av5_r;
  logic                  nu5_r, nv5_r;
  logic [R4W-1:0]        r4_nxt;
  logic signed [DW-1:0]  k2r4_nxt;

  assign r4_nxt   = r2sq4_r[F+R4W-1:F];
  assign k2r4_nxt = k2_r * $signed({1'b0, r4_nxt});

  // Stage 6: denominator
  logic                 v6_r;
  logic signed [DW-1:0] d6_r;
  logic [W-1:0]         au6_r, av6_r;
  logic                 nu6_r, nv6_r;
  logic signed [DW-1:0] d_nxt;

  assign d_nxt = D_ONE + DW'(k1r2_5_r) + k2r4_5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_chan.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      au1_r    <= au_nxt;
      av1_r    <= av_nxt;
      nu1_r    <= in_chan.coord_u[W-1];
      nv1_r    <= in_chan.coord_v[W-1];

      pu2_r    <= pu_nxt;
      pv2_r    <= pv_nxt;
      au2_r    <= au1_r;
      av2_r    <= av1_r;
      nu2_r    <= nu1_r;
      nv2_r    <= nv1_r;

      r2_3_r   <= sum_nxt[2*W-1:F];
      au3_r    <= au2_r;
      av3_r    <= av2_r;
      nu3_r    <= nu2_r;
      nv3_r    <= nv2_r;

      r2sq4_r  <= r2sq_nxt;
      k1r2_4_r <= k1r2_nxt;
      au4_r    <= au3_r;
      av4_r    <= av3_r;
      nu4_r    <= nu3_r;
      nv4_r    <= nv3_r;

      k2r4_5_r <= k2r4_nxt;
      k1r2_5_r <= k1r2_4_r;
      au5_r    <= au4_r;
      av5_r    <= av4_r;
      nu5_r    <= nu4_r;
      nv5_r    <= nv4_r;

      d6_r     <= d_nxt;
      au6_r    <= au5_r;
      av6_r    <= av5_r;
      nu6_r    <= nu5_r;
      nv6_r    <= nv5_r;
    end
  end

  // Divider: entry 0 is the setup stage, entry k holds k quotient bits
  logic             dv_r  [QW+1];
  logic [DW-1:0]    dd_r  [QW+1];
  logic [DW-1:0]    ru_r  [QW+1];
  logic [DW-1:0]    rv_r  [QW+1];
  logic [QW-1:0]    qu_r  [QW+1];
  logic [QW-1:0]    qv_r  [QW+1];
  rdw_flags_t       fl_r  [QW+1];

  logic [DW-1:0] num_u, num_v, d_mag;
  rdw_flags_t    fl_nxt;

  assign num_u = DW'({au6_r, {PRE{1'b0}}});
  assign num_v = DW'({av6_r, {PRE{1'b0}}});
  assign d_mag = d6_r;

  always_comb begin
    fl_nxt.neg_u = nu6_r;
    fl_nxt.neg_v = nv6_r;
    fl_nxt.err   = d6_r[DW-1] || (d6_r == '0);
    // quotient would not fit the step count: certain saturation
    fl_nxt.ovf_u = num_u >= d_mag;
    fl_nxt.ovf_v = num_v >= d_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dd_r[0] <= d_mag;
      ru_r[0] <= num_u;
      rv_r[0] <= num_v;
      qu_r[0] <= '0;
      qv_r[0] <= '0;
      fl_r[0] <= fl_nxt;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [DW-1:0] two_u, two_v;
    logic          ge_u, ge_v;

    assign two_u = {ru_r[k-1][DW-2:0], 1'b0};
    assign two_v = {rv_r[k-1][DW-2:0], 1'b0};
    assign ge_u  = two_u >= dd_r[k-1];
    assign ge_v  = two_v >= dd_r[k-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else if (adv) begin
        dv_r[k] <= dv_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dd_r[k] <= dd_r[k-1];
        ru_r[k] <= ge_u ? (two_u - dd_r[k-1]) : two_u;
        rv_r[k] <= ge_v ? (two_v - dd_r[k-1]) : two_v;
        qu_r[k] <= {qu_r[k-1][QW-2:0], ge_u};
        qv_r[k] <= {qv_r[k-1][QW-2:0], ge_v};
        fl_r[k] <= fl_r[k-1];
      end
    end
  end

  // Output stage: round half away from zero, saturate, apply sign
  logic [QW:0]   rsum_u, rsum_v;
  logic [QW-1:0] qr_u, qr_v, lim_u, lim_v, mag_u, mag_v;
  logic          sat_u, sat_v;
  logic [W-1:0]  s_nxt, t_nxt;
  status_t       st_nxt;
  rdw_flags_t    fl_o;

  assign fl_o   = fl_r[QW];
  assign rsum_u = {1'b0, qu_r[QW]} + 1'b1;
  assign rsum_v = {1'b0, qv_r[QW]} + 1'b1;
  assign qr_u   = rsum_u[QW:1];
  assign qr_v   = rsum_v[QW:1];
  assign lim_u  = fl_o.neg_u ? LIM_NEG : LIM_POS;
  assign lim_v  = fl_o.neg_v ? LIM_NEG : LIM_POS;
  assign sat_u  = fl_o.ovf_u || (qr_u > lim_u);
  assign sat_v  = fl_o.ovf_v || (qr_v > lim_v);
  assign mag_u  = sat_u ? lim_u : qr_u;
  assign mag_v  = sat_v ? lim_v : qr_v;

  always_comb begin
    if (fl_o.err) begin
      s_nxt  = '0;
      t_nxt  = '0;
      st_nxt = STATUS_ERR;
    end else begin
      s_nxt  = fl_o.neg_u ? (~mag_u[W-1:0] + 1'b1) : mag_u[W-1:0];
      t_nxt  = fl_o.neg_v ? (~mag_v[W-1:0] + 1'b1) : mag_v[W-1:0];
      st_nxt = (sat_u || sat_v) ? STATUS_SAT : STATUS_OK;
    end
  end

  logic         out_v_r;
  logic [W-1:0] out_s_r, out_t_r;
  status_t      out_st_r;

  // Advance the whole line unless a held word is waiting on the sink
  assign adv = !out_v_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_s_r  <= s_nxt;
      out_t_r  <= t_nxt;
      out_st_r <= st_nxt;
    end
  end

  assign in_chan.ready        = adv;
  assign out_chan.valid       = out_v_r;
  assign out_chan.warped_s    = out_s_r;
  assign out_chan.warped_t    = out_t_r;
  assign out_chan.status_code = out_st_r;

endmodule
`default_nettype wire

[test/tb_radial_distortion_warp.sv]
`timescale 1ns / 100ps
module tb_radial_distortion_warp;
  import rdw_pkg::*;

  localparam int CW         = 16;
  localparam int FRAC       = CW - 2;
  localparam int LATENCY    = CW + 9;
  localparam int SWEEP_LEN  = 170;
  localparam int N_SWEEPS   = 9;
  localparam longint LIMIT  = 1_000_000;

  typedef struct {
    logic [CW-1:0] s;
    logic [CW-1:0] t;
    status_t       status;
  } warp_word_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  cfg_index_t             cfg_index;
  logic [COEFF_WIDTH-1:0] cfg_data;

  rdw_in_if  #(.COORD_WIDTH(CW)) in_chan ();
  rdw_out_if #(.COORD_WIDTH(CW)) out_chan ();

  radial_distortion_warp #(.COORD_WIDTH(CW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Coefficients as the block should hold them
  logic signed [COEFF_WIDTH-1:0] coeff_k1;
  logic signed [COEFF_WIDTH-1:0] coeff_k2;

  warp_word_t warp_expect_q[$];
  int         fail_count;
  longint     cycle_count;
  bit         src_calm;
  bit         sink_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("tb_radial_distortion_warp: done, errors");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Round |c| * 2^(FRAC+12) / d half away from zero and clamp to the field
  function automatic logic [CW-1:0] scale_coord(longint c, longint d, inout bit sat);
    longint unsigned mag;
    longint unsigned num;
    longint unsigned ud;
    longint unsigned q;
    longint unsigned rem;
    longint unsigned lim;
    bit              neg;
    neg = c < 0;
    mag = neg ? longint'(-c) : c;
    ud  = d;
    num = mag << (FRAC + COEFF_FRAC);
    q   = num / ud;
    rem = num % ud;
    if ((rem << 1) >= ud) q = q + 1;
    lim = (64'd1 << (CW - 1)) - (neg ? 64'd0 : 64'd1);
    if (q > lim) begin
      sat = 1'b1;
      q   = lim;
    end
    if (neg) q = -q;
    return q[CW-1:0];
  endfunction

  function automatic warp_word_t predict_warp(logic [CW-1:0] u_raw, logic [CW-1:0] v_raw);
    warp_word_t w;
    longint     su;
    longint     sv;
    longint     au;
    longint     av;
    longint     r2;
    longint     r4;
    longint     k1;
    longint     k2;
    longint     den;
    bit         sat;
    su  = longint'($signed(u_raw));
    sv  = longint'($signed(v_raw));
    k1  = longint'(coeff_k1);
    k2  = longint'(coeff_k2);
    au  = su < 0 ? -su : su;
    av  = sv < 0 ? -sv : sv;
    r2  = (au * au + av * av) >> FRAC;
    r4  = (r2 * r2) >> FRAC;
    den = (64'sd1 <<< (FRAC + COEFF_FRAC)) + k1 * r2 + k2 * r4;
    sat = 1'b0;
    if (den <= 0) begin
      w.s      = '0;
      w.t      = '0;
      w.status = STATUS_ERR;
    end else begin
      w.s      = scale_coord(su, den, sat);
      w.t      = scale_coord(sv, den, sat);
      w.status = sat ? STATUS_SAT : STATUS_OK;
    end
    return w;
  endfunction

  function automatic logic [CW-1:0] random_coord();
    int r;
    int x;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      x = $urandom_range(0, 65535);
    end else if (r < 75) begin
      x = int'($urandom_range(0, 32768)) - 16384;
    end else if (r < 90) begin
      x = int'($urandom_range(0, 1024)) - 512;
    end else begin
      case ($urandom_range(0, 6))
        0: x = -32768;
        1: x = -32767;
        2: x = -1;
        3: x = 0;
        4: x = 1;
        5: x = 32766;
        default: x = 32767;
      endcase
    end
    return x[CW-1:0];
  endfunction

  // Send one word; called at a falling edge, returns at a falling edge with valid held
  task automatic send_coord(logic [CW-1:0] u, logic [CW-1:0] v);
    int gap;
    gap = src_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid   = 1'b1;
    in_chan.coord_u = u;
    in_chan.coord_v = v;
    do @(posedge clk); while (!in_chan.ready);
    warp_expect_q.insert(warp_expect_q.size(), predict_warp(u, v));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_chan.valid = 1'b0;
    while (warp_expect_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_coeff(cfg_index_t idx, logic [COEFF_WIDTH-1:0] value);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == CFG_K1) coeff_k1 = value;
    else coeff_k2 = value;
  endtask

  task automatic set_coeffs(int k1, int k2);
    drain_results();
    write_coeff(CFG_K1, k1[COEFF_WIDTH-1:0]);
    write_coeff(CFG_K2, k2[COEFF_WIDTH-1:0]);
  endtask

  task automatic test_identity_extremes();
    set_coeffs(0, 0);
    send_coord(16'h0000, 16'h0000);
    send_coord(16'h7fff, 16'h8000);
    send_coord(16'h8000, 16'h7fff);
    send_coord(16'h0001, 16'hffff);
    send_coord(16'h4000, 16'hc000);
    send_coord(16'hffff, 16'h0001);
  endtask

  task automatic test_not_positive_and_saturation();
    // k1 = -1.0: d hits zero exactly on the unit circle
    set_coeffs(-4096, 0);
    send_coord(16'd16384, 16'd0);
    send_coord(16'd0, 16'd16384);
    send_coord(16'h8000, 16'h8000);
    send_coord(16'd16000, 16'd0);
    send_coord(-16'sd16000, 16'd0);
    send_coord(16'd0, -16'sd16000);
    send_coord(16'd100, 16'd100);
  endtask

  task automatic test_coeff_extremes();
    set_coeffs(32767, 32767);
    send_coord(16'h8000, 16'h8000);
    send_coord(16'h0001, 16'h0001);
    set_coeffs(-32768, -32768);
    send_coord(16'h7fff, 16'h7fff);
    send_coord(16'h0000, 16'h0000);
    send_coord(16'h0001, 16'h0000);
  endtask

  task automatic test_second_coeff();
    set_coeffs(0, -4096);
    send_coord(16'd16384, 16'd0);
    send_coord(16'd15000, 16'd0);
    send_coord(16'd0, -16'sd15000);
    send_coord(16'd8000, 16'd8000);
  endtask

  task automatic test_random_sweeps();
    int k1_set[N_SWEEPS];
    int k2_set[N_SWEEPS];
    k1_set = '{0, 32767, -32768, -32768, 32767, -4096, 1024, 0, 0};
    k2_set = '{0, 32767, -32768, 32767, -32768, 0, 512, 0, 0};
    for (int p = 0; p < N_SWEEPS; p++) begin
      if (p >= 7) begin
        k1_set[p] = int'($signed(16'($urandom)));
        k2_set[p] = int'($signed(16'($urandom)));
      end
      src_calm  = (p == 2);
      sink_calm = (p == 2) || (p == 6);
      set_coeffs(k1_set[p], k2_set[p]);
      for (int n = 0; n < SWEEP_LEN; n++) begin
        // hold off the sender until the pipeline is empty once per sweep
        if (n == SWEEP_LEN / 2) drain_results();
        send_coord(random_coord(), random_coord());
      end
    end
    src_calm  = 1'b0;
    sink_calm = 1'b0;
  endtask

  // Result side: random back-pressure
  initial begin
    int gap;
    out_chan.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = sink_calm ? 0 : pick_gap();
      if (gap > 0) begin
        out_chan.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_chan.ready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    warp_word_t w;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (warp_expect_q.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected word: s=%0d t=%0d status=%0d", $signed(out_chan.warped_s),
                   $signed(out_chan.warped_t), out_chan.status_code);
        fail_count = fail_count + 1;
      end else begin
        w = warp_expect_q.pop_front();
        if (out_chan.warped_s !== w.s || out_chan.warped_t !== w.t ||
            out_chan.status_code !== w.status) begin
          if (fail_count < 10)
            $display("mismatch: expected s=%0d t=%0d status=%0d, got s=%0d t=%0d status=%0d",
                     $signed(w.s), $signed(w.t), w.status, $signed(out_chan.warped_s),
                     $signed(out_chan.warped_t), out_chan.status_code);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  initial begin
    fail_count      = 0;
    cycle_count     = 0;
    src_calm        = 1'b0;
    sink_calm       = 1'b0;
    coeff_k1        = '0;
    coeff_k2        = '0;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = CFG_K1;
    cfg_data        = '0;
    in_chan.valid   = 1'b0;
    in_chan.coord_u = '0;
    in_chan.coord_v = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_identity_extremes();
    test_not_positive_and_saturation();
    test_coeff_extremes();
    test_second_coeff();
    test_random_sweeps();

    drain_results();
    // any extra word in this window is flagged by the checker
    repeat (LATENCY + 10) @(posedge clk);
    fail_count = fail_count + warp_expect_q.size();
    if (fail_count == 0) begin
      $display("tb_radial_distortion_warp: done, clean");
    end else begin
      $display("tb_radial_distortion_warp: done, errors");
    end
    $finish;
  end

endmodule
